[design/svna_pkg.sv]
// shared types, constants and codes for the smooth vertex normal accumulator
`default_nettype none

package svna_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int POS_W        = 16;
  localparam int EDGE_W       = POS_W + 1;
  localparam int ACC_W        = 24;
  localparam int NRM_W        = 16;
  localparam int CR_W         = 36;
  localparam int MAG_W        = 36;
  localparam int ONE_Q14      = 16384;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_TRI  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [EDGE_W-1:0] edge_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [NRM_W-1:0]  nrm_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [VTX_W-1:0] vertex_index;
    pos_t             pos_x;
    pos_t             pos_y;
    pos_t             pos_z;
    logic [VTX_W-1:0] corner_a;
    logic [VTX_W-1:0] corner_b;
    logic [VTX_W-1:0] corner_c;
  } in_beat_t;

  typedef struct packed {
    logic [VTX_W-1:0] normal_vertex;
    nrm_t             normal_x;
    nrm_t             normal_y;
    nrm_t             normal_z;
    logic             zero_length;
  } out_beat_t;

  typedef struct packed {
    logic start;
    logic tri_mode;
  } core_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } core_rsp_t;

endpackage

`default_nettype wire

[design/svna_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module svna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/svna_core.sv]
// iterative cross product and unit-length normalizer around one multiplier
`default_nettype none

module svna_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  svna_pkg::core_req_t req_i,
  input  svna_pkg::edge_t     e1_i [3],
  input  svna_pkg::edge_t     e2_i [3],
  input  svna_pkg::acc_t      acc_i [3],
  output svna_pkg::core_rsp_t rsp_o,
  output svna_pkg::nrm_t      n_o [3]
);

  localparam logic [3:0] C_IDLE  = 4'd0;
  localparam logic [3:0] C_CROSS = 4'd1;
  localparam logic [3:0] C_ABS   = 4'd2;
  localparam logic [3:0] C_SHIFT = 4'd3;
  localparam logic [3:0] C_SQ    = 4'd4;
  localparam logic [3:0] C_SQRT  = 4'd5;
  localparam logic [3:0] C_DIVI  = 4'd6;
  localparam logic [3:0] C_DIV   = 4'd7;
  localparam logic [3:0] C_DONE  = 4'd8;

  localparam int MW = svna_pkg::MAG_W;
  localparam int CW = svna_pkg::CR_W;
  localparam int NW = svna_pkg::NRM_W;

  logic [3:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] comp_q, comp_d;

  svna_pkg::edge_t     e1_q [3], e1_d [3];
  svna_pkg::edge_t     e2_q [3], e2_d [3];
  logic signed [CW-1:0] v_q [3], v_d [3];
  logic [MW-1:0]       m_q [3], m_d [3];
  logic                neg_q [3], neg_d [3];
  svna_pkg::nrm_t      n_q [3], n_d [3];
  logic                zero_q, zero_d;

  logic signed [63:0] prod_q, prod_d;
  logic [63:0]        sum_q, sum_d;
  logic [63:0]        rem_q, rem_d;
  logic [63:0]        res_q, res_d;
  logic [63:0]        bit_q, bit_d;
  logic [31:0]        len_q, len_d;
  logic [14:0]        quo_q, quo_d;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [1:0]         sq_idx;
  logic [2:0]         cr_idx;
  logic [63:0]        sub_b;
  logic [64:0]        diff;
  logic               ge;
  logic               big, high, all_zero;
  logic [14:0]        q_full, q_clip;
  logic [NW-1:0]      q_ext;

  assign sq_idx = (cnt_q[1:0] == 2'd3) ? 2'd2 : cnt_q[1:0];
  assign cr_idx = cnt_q[2:0] - 3'd1;

  // shared multiplier: cross terms, then squares
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == C_CROSS) begin
      case (cnt_q[2:0])
        3'd0: begin mul_a = 32'(e1_q[1]); mul_b = 32'(e2_q[2]); end
        3'd1: begin mul_a = 32'(e1_q[2]); mul_b = 32'(e2_q[1]); end
        3'd2: begin mul_a = 32'(e1_q[2]); mul_b = 32'(e2_q[0]); end
        3'd3: begin mul_a = 32'(e1_q[0]); mul_b = 32'(e2_q[2]); end
        3'd4: begin mul_a = 32'(e1_q[0]); mul_b = 32'(e2_q[1]); end
        3'd5: begin mul_a = 32'(e1_q[1]); mul_b = 32'(e2_q[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else begin
      mul_a = signed'({2'b00, m_q[sq_idx][29:0]});
      mul_b = signed'({2'b00, m_q[sq_idx][29:0]});
    end
  end

  assign mul_p = mul_a * mul_b;

  // shared compare-subtract: root digits and quotient bits
  assign sub_b = (state_q == C_SQRT) ? (res_q + bit_q) : bit_q;
  assign diff  = {1'b0, rem_q} - {1'b0, sub_b};
  assign ge    = ~diff[64];

  assign q_full = {quo_q[13:0], ge};
  assign q_clip = (q_full > 15'(svna_pkg::ONE_Q14)) ? 15'(svna_pkg::ONE_Q14) : q_full;
  assign q_ext  = {1'b0, q_clip};

  always_comb begin
    big      = 1'b0;
    high     = 1'b0;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      big      = big | (|m_q[i][MW-1:30]);
      high     = high | (|m_q[i][MW-1:29]);
      all_zero = all_zero & (v_q[i] == '0);
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    e1_d    = e1_q;
    e2_d    = e2_q;
    v_d     = v_q;
    m_d     = m_q;
    neg_d   = neg_q;
    n_d     = n_q;
    zero_d  = zero_q;
    prod_d  = prod_q;
    sum_d   = sum_q;
    rem_d   = rem_q;
    res_d   = res_q;
    bit_d   = bit_q;
    len_d   = len_q;
    quo_d   = quo_q;
    unique case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          zero_d = 1'b0;
          cnt_d  = '0;
          if (req_i.tri_mode) begin
            e1_d    = e1_i;
            e2_d    = e2_i;
            state_d = C_CROSS;
          end else begin
            for (int i = 0; i < 3; i++) begin
              v_d[i] = CW'(acc_i[i]);
            end
            state_d = C_ABS;
          end
        end
      end
      C_CROSS: begin
        if (cnt_q != 6'd6) begin
          prod_d = mul_p;
        end
        if (cnt_q != 6'd0) begin
          if (!cr_idx[0]) begin
            v_d[cr_idx[2:1]] = prod_q[CW-1:0];
          end else begin
            v_d[cr_idx[2:1]] = v_q[cr_idx[2:1]] - prod_q[CW-1:0];
          end
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd6) begin
          state_d = C_ABS;
        end
      end
      C_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg_d[i] = v_q[i][CW-1];
          m_d[i]   = v_q[i][CW-1] ? MW'(-v_q[i]) : MW'(v_q[i]);
        end
        if (all_zero) begin
          zero_d = 1'b1;
          for (int i = 0; i < 3; i++) begin
            n_d[i] = '0;
          end
          state_d = C_DONE;
        end else begin
          state_d = C_SHIFT;
        end
      end
      C_SHIFT: begin
        if (big) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] >> 1;
        end else if (!high) begin
          for (int i = 0; i < 3; i++) m_d[i] = m_q[i] << 1;
        end else begin
          cnt_d   = '0;
          sum_d   = '0;
          state_d = C_SQ;
        end
      end
      C_SQ: begin
        if (cnt_q != 6'd3) begin
          prod_d = mul_p;
        end
        if (cnt_q != 6'd0) begin
          sum_d = sum_q + prod_q;
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd3) begin
          rem_d   = sum_q + prod_q;
          res_d   = '0;
          bit_d   = 64'd1 << 62;
          cnt_d   = '0;
          state_d = C_SQRT;
        end
      end
      C_SQRT: begin
        if (ge) begin
          rem_d = diff[63:0];
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          len_d   = res_d[31:0];
          comp_d  = '0;
          state_d = C_DIVI;
        end
      end
      C_DIVI: begin
        rem_d   = 64'({m_q[comp_q][29:0], 14'b0}) + 64'(len_q >> 1);
        bit_d   = 64'({len_q, 14'b0});
        quo_d   = '0;
        cnt_d   = '0;
        state_d = C_DIV;
      end
      C_DIV: begin
        if (ge) begin
          rem_d = diff[63:0];
        end
        quo_d = q_full;
        bit_d = bit_q >> 1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd14) begin
          n_d[comp_q] = neg_q[comp_q] ? -q_ext : q_ext;
          if (comp_q == 2'd2) begin
            state_d = C_DONE;
          end else begin
            comp_d  = comp_q + 2'd1;
            state_d = C_DIVI;
          end
        end
      end
      C_DONE: begin
        state_d = C_IDLE;
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
      comp_q  <= '0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      zero_q  <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e1_q   <= e1_d;
    e2_q   <= e2_d;
    v_q    <= v_d;
    m_q    <= m_d;
    neg_q  <= neg_d;
    n_q    <= n_d;
    prod_q <= prod_d;
    sum_q  <= sum_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    len_q  <= len_d;
    quo_q  <= quo_d;
  end

  assign rsp_o.busy = (state_q != C_IDLE);
  assign rsp_o.done = (state_q == C_DONE);
  assign rsp_o.zero = zero_q;
  assign n_o        = n_q;

endmodule

`default_nettype wire

[design/smooth_vertex_normal_accumulator_top.sv]
// top level: vertex stores, action sequencer and result register
//
//   port group   dir  flow control        what one beat carries
//   in_*         in   in_valid_i/stall_o  one action: load, add triangle or read
//   out_*        out  out_valid_o/stall_i one normalized vertex normal (reads only)
//
// a load writes both stores on its accept and the block stays ready
// add triangle: position reads of a, b and c, the shared core, then a
//   read-modify-write of the accumulator per corner; stalled until the last
//   write, and a degenerate triangle skips the core's normalize
// read: accumulator read, the core, then the result register; a zero vector
//   skips the normalize; stalled until the result register, once free, takes it
// in the core the normalizing shift moves one bit a cycle, and the 32-step
//   square root and the three divides share one compare-subtract
// stores need no clearing after reset; the result register lets a finished
//   read wait on out_stall_i while the next beat is accepted
`default_nettype none

module smooth_vertex_normal_accumulator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  svna_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output svna_pkg::out_beat_t out_beat_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POS   = 3'd1;
  localparam logic [2:0] S_RDACC = 3'd2;
  localparam logic [2:0] S_CORE  = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam int AW = svna_pkg::ACC_W;
  localparam int VW = svna_pkg::VTX_W;
  localparam int PW = svna_pkg::POS_W;

  localparam logic signed [AW:0] SAT_HI = (AW+1)'((64'sd1 <<< (AW - 1)) - 64'sd1);
  localparam logic signed [AW:0] SAT_LO = (AW+1)'(-(64'sd1 <<< (AW - 1)));

  logic [2:0]    state_q, state_d;
  logic [2:0]    cnt_q, cnt_d;
  logic          ph_q, ph_d;
  logic [1:0]    act_q, act_d;
  logic [VW-1:0] vi_q, vi_d;
  logic [VW-1:0] ca_q, ca_d, cb_q, cb_d, cc_q, cc_d;

  svna_pkg::pos_t p_q [3][3];
  svna_pkg::pos_t p_d [3][3];

  logic                out_valid_q, out_valid_d;
  svna_pkg::out_beat_t out_q, out_d;

  logic accept;
  logic [VW-1:0] corner;

  // stores
  logic              pos_we;
  logic [3*PW-1:0]   pos_wdata, pos_rdata;
  logic              acc_we;
  logic [VW-1:0]     acc_waddr, acc_raddr;
  logic [3*AW-1:0]   acc_wdata, acc_rdata;

  svna_pkg::acc_t      acc_rd [3];
  svna_pkg::acc_t      acc_new [3];
  svna_pkg::edge_t     e1 [3];
  svna_pkg::edge_t     e2 [3];
  svna_pkg::core_req_t core_req;
  svna_pkg::core_rsp_t core_rsp;
  svna_pkg::nrm_t      core_n [3];

  function automatic svna_pkg::acc_t sat_add(svna_pkg::acc_t a, svna_pkg::nrm_t b);
    logic signed [AW:0] s;
    s = (AW+1)'(a) + (AW+1)'(b);
    if (s > SAT_HI) begin
      s = SAT_HI;
    end else if (s < SAT_LO) begin
      s = SAT_LO;
    end
    return s[AW-1:0];
  endfunction

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    case (cnt_q)
      3'd0:    corner = ca_q;
      3'd1:    corner = cb_q;
      default: corner = cc_q;
    endcase
  end

  // position store: x, y, z packed high to low
  assign pos_we    = accept && (in_beat_i.action == svna_pkg::ACT_LOAD);
  assign pos_wdata = {in_beat_i.pos_x, in_beat_i.pos_y, in_beat_i.pos_z};

  svna_ram #(
    .WIDTH(3 * PW),
    .DEPTH(svna_pkg::MAX_VERTICES)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (pos_we),
    .waddr_i(in_beat_i.vertex_index),
    .wdata_i(pos_wdata),
    .raddr_i(corner),
    .rdata_o(pos_rdata)
  );

  // accumulator store: a load clears, a triangle does read-modify-write per corner
  for (genvar g = 0; g < 3; g++) begin : g_acc
    assign acc_rd[g]  = acc_rdata[(3-g)*AW-1 -: AW];
    assign acc_new[g] = sat_add(acc_rd[g], core_n[g]);
  end

  assign acc_we    = pos_we || (state_q == S_ACC && ph_q);
  assign acc_waddr = (state_q == S_ACC) ? corner : in_beat_i.vertex_index;
  assign acc_wdata = (state_q == S_ACC) ? {acc_new[0], acc_new[1], acc_new[2]} : '0;
  assign acc_raddr = (state_q == S_ACC) ? corner : vi_q;

  svna_ram #(
    .WIDTH(3 * AW),
    .DEPTH(svna_pkg::MAX_VERTICES)
  ) u_acc_ram (
    .clk_i  (clk_i),
    .we_i   (acc_we),
    .waddr_i(acc_waddr),
    .wdata_i(acc_wdata),
    .raddr_i(acc_raddr),
    .rdata_o(acc_rdata)
  );

  // edges from the middle corner
  for (genvar g = 0; g < 3; g++) begin : g_edge
    assign e1[g] = svna_pkg::EDGE_W'(p_q[0][g]) - svna_pkg::EDGE_W'(p_q[1][g]);
    assign e2[g] = svna_pkg::EDGE_W'(p_q[2][g]) - svna_pkg::EDGE_W'(p_q[1][g]);
  end

  assign core_req.start    = (state_q == S_POS && cnt_q == 3'd4) ||
                             (state_q == S_RDACC && ph_q);
  assign core_req.tri_mode = (state_q == S_POS);

  svna_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (core_req),
    .e1_i  (e1),
    .e2_i  (e2),
    .acc_i (acc_rd),
    .rsp_o (core_rsp),
    .n_o   (core_n)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ph_d        = ph_q;
    act_d       = act_q;
    vi_d        = vi_q;
    ca_d        = ca_q;
    cb_d        = cb_q;
    cc_d        = cc_q;
    p_d         = p_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d = in_beat_i.action;
          vi_d  = in_beat_i.vertex_index;
          ca_d  = in_beat_i.corner_a;
          cb_d  = in_beat_i.corner_b;
          cc_d  = in_beat_i.corner_c;
          cnt_d = '0;
          ph_d  = 1'b0;
          case (in_beat_i.action)
            svna_pkg::ACT_TRI:  state_d = S_POS;
            svna_pkg::ACT_READ: state_d = S_RDACC;
            default:            state_d = S_IDLE;
          endcase
        end
      end
      S_POS: begin
        // read a, b, c back to back; each data word comes the cycle after its address
        if (cnt_q != 3'd0 && cnt_q != 3'd4) begin
          p_d[cnt_q[1:0] - 2'd1][0] = pos_rdata[3*PW-1 -: PW];
          p_d[cnt_q[1:0] - 2'd1][1] = pos_rdata[2*PW-1 -: PW];
          p_d[cnt_q[1:0] - 2'd1][2] = pos_rdata[PW-1 -: PW];
        end
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          state_d = S_CORE;
        end
      end
      S_RDACC: begin
        ph_d = !ph_q;
        if (ph_q) begin
          state_d = S_CORE;
        end
      end
      S_CORE: begin
        if (core_rsp.done) begin
          cnt_d   = '0;
          ph_d    = 1'b0;
          state_d = (act_q == svna_pkg::ACT_TRI) ? S_ACC : S_OUT;
        end
      end
      S_ACC: begin
        // read phase then write phase, so a repeated corner sees its own update
        ph_d = !ph_q;
        if (ph_q) begin
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd2) begin
            state_d = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_d.normal_vertex = vi_q;
          out_d.normal_x      = core_n[0];
          out_d.normal_y      = core_n[1];
          out_d.normal_z      = core_n[2];
          out_d.zero_length   = core_rsp.zero;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ph_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    vi_q  <= vi_d;
    ca_q  <= ca_d;
    cb_q  <= cb_d;
    cc_q  <= cc_d;
    p_q   <= p_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // core only runs while the sequencer waits on it
  a_core_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !core_rsp.busy)
    else $error("core busy while sequencer idle");

  a_done_in_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_rsp.done |-> (state_q == S_CORE))
    else $error("core finished outside core wait");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && (!out_valid_q || !out_stall_i)) |=> out_valid_q)
    else $error("read result not presented");

  a_acc_write_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_we |-> (state_q == S_ACC || state_q == S_IDLE))
    else $error("accumulator written in wrong state");

endmodule

`default_nettype wire
